// File: rtl/rbp_pkg.sv
package rbp_pkg;

   localparam int COUNT_WIDTH_DEF = 16;
   localparam int TIME_WIDTH_DEF  = 40;

   // register field widths
   localparam int BASE_W     = 12;
   localparam int CEIL_W     = 17;
   localparam int ALIM_W     = 10;
   localparam int DLIM_W     = 14;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   // shift distance at or beyond which any nonzero base exceeds any ceiling
   localparam int SHIFT_SPAN = CEIL_W;
   localparam int STEP_W     = $clog2(SHIFT_SPAN + 1);
   localparam int SHIFTED_W  = BASE_W + CEIL_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RETRY_BASE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CEILING    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEFER_BASE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ATT_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DEF_LIMIT  = 3'd4;

   // register reset values
   localparam logic [BASE_W-1:0] RETRY_BASE_RST = 12'd30;
   localparam logic [CEIL_W-1:0] CEILING_RST    = 17'd900;
   localparam logic [BASE_W-1:0] DEFER_BASE_RST = 12'd5;
   localparam logic [ALIM_W-1:0] ATT_LIMIT_RST  = 10'd8;
   localparam logic [DLIM_W-1:0] DEF_LIMIT_RST  = 14'd48;

   // outcome codes
   localparam logic [2:0] OC_OK         = 3'd0;
   localparam logic [2:0] OC_RETRYABLE  = 3'd1;
   localparam logic [2:0] OC_TIMEOUT    = 3'd2;
   localparam logic [2:0] OC_TERMINAL   = 3'd3;
   localparam logic [2:0] OC_NOT_READY  = 3'd4;
   localparam logic [2:0] OC_BUSY       = 3'd5;
   localparam logic [2:0] OC_INCOMPLETE = 3'd6;

   // status codes
   localparam logic [1:0] ST_SCHEDULED = 2'd0;
   localparam logic [1:0] ST_COMPLETED = 2'd1;
   localparam logic [1:0] ST_DEAD      = 2'd2;
   localparam logic [1:0] ST_FAILED    = 2'd3;

   typedef struct packed {
      logic [BASE_W-1:0] retry_base;
      logic [CEIL_W-1:0] ceiling;
      logic [BASE_W-1:0] dfr_base;
      logic [ALIM_W-1:0] att_limit;
      logic [DLIM_W-1:0] def_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0] status;
      logic       wait_en;
   } ctl_type;

endpackage

// File: rtl/rbp_req_if.sv
interface rbp_req_if
   import rbp_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
   parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) ();
   logic                   valid;
   logic                   ready;
   logic [2:0]             outcome;
   logic [COUNT_WIDTH-1:0] attempt_count;
   logic [COUNT_WIDTH-1:0] deferral_count;
   logic [TIME_WIDTH-1:0]  time_now;
   logic                   attempts_unbounded;
   logic                   deferrals_unbounded;

   modport source (output valid, outcome, attempt_count, deferral_count, time_now,
                   attempts_unbounded, deferrals_unbounded, input ready);
   modport sink   (input valid, outcome, attempt_count, deferral_count, time_now,
                   attempts_unbounded, deferrals_unbounded, output ready);
endinterface

// File: rtl/rbp_rsp_if.sv
interface rbp_rsp_if
   import rbp_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
   parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             new_status;
   logic [COUNT_WIDTH-1:0] new_attempt_count;
   logic [COUNT_WIDTH-1:0] new_deferral_count;
   logic [TIME_WIDTH:0]    next_attempt_time;

   modport source (output valid, new_status, new_attempt_count, new_deferral_count,
                   next_attempt_time, input ready);
   modport sink   (input valid, new_status, new_attempt_count, new_deferral_count,
                   next_attempt_time, output ready);
endinterface

// File: rtl/rbp_csr.sv
module rbp_csr
   import rbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_RETRY_BASE: cfg_in.retry_base = csr_wdata[BASE_W-1:0];
            REG_CEILING:    cfg_in.ceiling    = csr_wdata[CEIL_W-1:0];
            REG_DEFER_BASE: cfg_in.dfr_base   = csr_wdata[BASE_W-1:0];
            REG_ATT_LIMIT:  cfg_in.att_limit  = csr_wdata[ALIM_W-1:0];
            REG_DEF_LIMIT:  cfg_in.def_limit  = csr_wdata[DLIM_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_base <= RETRY_BASE_RST;
         cfg_ff.ceiling    <= CEILING_RST;
         cfg_ff.dfr_base   <= DEFER_BASE_RST;
         cfg_ff.att_limit  <= ATT_LIMIT_RST;
         cfg_ff.def_limit  <= DEF_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

// File: rtl/rbp_decode.sv
module rbp_decode
   import rbp_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
   parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   rbp_req_if.sink                req_chan,
   input  logic                   out_ready,
   output logic                   out_valid,
   output ctl_type                out_ctl,
   output logic [COUNT_WIDTH-1:0] out_att,
   output logic [COUNT_WIDTH-1:0] out_def,
   output logic [TIME_WIDTH-1:0]  out_time,
   output logic [BASE_W-1:0]      out_base,
   output logic [STEP_W-1:0]      out_steps,
   output logic                   out_far
);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam int CMP_W = COUNT_WIDTH > DLIM_W ? COUNT_WIDTH : DLIM_W;

   logic                   valid_ff;
   ctl_type                ctl_ff, ctl_in;
   logic [COUNT_WIDTH-1:0] att_ff, att_in, def_ff, def_in;
   logic [TIME_WIDTH-1:0]  time_ff;
   logic [BASE_W-1:0]      base_ff, base_in;
   logic [STEP_W-1:0]      steps_ff, steps_in;
   logic                   far_ff, far_in;
   logic                   load;

   assign req_chan.ready = !valid_ff || out_ready;
   assign load = req_chan.valid && req_chan.ready;

   always_comb begin
      logic [COUNT_WIDTH-1:0] old_cnt;
      logic [COUNT_WIDTH-1:0] new_cnt;
      logic [COUNT_WIDTH-1:0] steps_full;
      logic                   counted;
      logic                   unb;
      logic [CMP_W-1:0]       limit;

      ctl_in.status  = ST_SCHEDULED;
      ctl_in.wait_en = 1'b0;
      att_in  = req_chan.attempt_count;
      def_in  = req_chan.deferral_count;
      base_in = cfg.retry_base;
      counted = 1'b0;
      old_cnt = req_chan.attempt_count;
      unb     = req_chan.attempts_unbounded;
      limit   = CMP_W'(cfg.att_limit);

      unique case (req_chan.outcome) inside
         OC_OK:       ctl_in.status = ST_COMPLETED;
         OC_TERMINAL: ctl_in.status = ST_FAILED;
         OC_RETRYABLE, OC_TIMEOUT: begin
            counted = 1'b1;
            def_in  = '0;
         end
         OC_NOT_READY, OC_BUSY: begin
            counted = 1'b1;
            old_cnt = req_chan.deferral_count;
            unb     = req_chan.deferrals_unbounded;
            limit   = CMP_W'(cfg.def_limit);
            base_in = cfg.dfr_base;
         end
         OC_INCOMPLETE: def_in = '0;
         default: ;
      endcase

      // saturating count; shift distance is new count minus one
      new_cnt    = (old_cnt == COUNT_MAX) ? COUNT_MAX : old_cnt + 1'b1;
      steps_full = (old_cnt == COUNT_MAX) ? COUNT_MAX - 1'b1 : old_cnt;
      far_in     = steps_full >= COUNT_WIDTH'(SHIFT_SPAN);
      steps_in   = steps_full[STEP_W-1:0];

      if (counted) begin
         if (req_chan.outcome == OC_NOT_READY || req_chan.outcome == OC_BUSY) begin
            def_in = new_cnt;
         end else begin
            att_in = new_cnt;
         end
         if (!unb && CMP_W'(new_cnt) >= limit) begin
            ctl_in.status = ST_DEAD;
         end else begin
            ctl_in.wait_en = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctl_ff   <= ctl_in;
         att_ff   <= att_in;
         def_ff   <= def_in;
         time_ff  <= req_chan.time_now;
         base_ff  <= base_in;
         steps_ff <= steps_in;
         far_ff   <= far_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_att   = att_ff;
   assign out_def   = def_ff;
   assign out_time  = time_ff;
   assign out_base  = base_ff;
   assign out_steps = steps_ff;
   assign out_far   = far_ff;
endmodule

// File: rtl/rbp_ladder.sv
module rbp_ladder
   import rbp_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
   parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ctl_type                in_ctl,
   input  logic [COUNT_WIDTH-1:0] in_att,
   input  logic [COUNT_WIDTH-1:0] in_def,
   input  logic [TIME_WIDTH-1:0]  in_time,
   input  logic [BASE_W-1:0]      in_base,
   input  logic [STEP_W-1:0]      in_steps,
   input  logic                   in_far,
   input  logic                   out_ready,
   output logic                   out_valid,
   output ctl_type                out_ctl,
   output logic [COUNT_WIDTH-1:0] out_att,
   output logic [COUNT_WIDTH-1:0] out_def,
   output logic [TIME_WIDTH-1:0]  out_time,
   output logic [CEIL_W-1:0]      out_delay
);
   // shift stage
   logic                   sh_valid_ff;
   ctl_type                sh_ctl_ff;
   logic [COUNT_WIDTH-1:0] sh_att_ff, sh_def_ff;
   logic [TIME_WIDTH-1:0]  sh_time_ff;
   logic [SHIFTED_W-1:0]   sh_val_ff, sh_val_in;
   logic                   sh_cap_ff, sh_cap_in;
   logic                   sh_ready;

   // clamp stage
   logic                   cl_valid_ff;
   ctl_type                cl_ctl_ff;
   logic [COUNT_WIDTH-1:0] cl_att_ff, cl_def_ff;
   logic [TIME_WIDTH-1:0]  cl_time_ff;
   logic [CEIL_W-1:0]      cl_delay_ff, cl_delay_in;
   logic                   cl_ready;

   assign cl_ready = !cl_valid_ff || out_ready;
   assign sh_ready = !sh_valid_ff || cl_ready;
   assign in_ready = sh_ready;

   // with a wait, a zero base or a long shift lands on the ceiling
   always_comb begin
      sh_val_in = SHIFTED_W'(in_base) << in_steps;
      sh_cap_in = in_far || (in_base == '0);
   end

   always_comb begin
      if (!sh_ctl_ff.wait_en) begin
         cl_delay_in = '0;
      end else if (sh_cap_ff || sh_val_ff > SHIFTED_W'(cfg.ceiling)) begin
         cl_delay_in = cfg.ceiling;
      end else begin
         cl_delay_in = sh_val_ff[CEIL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_valid_ff <= 1'b0;
         cl_valid_ff <= 1'b0;
      end else begin
         if (sh_ready) sh_valid_ff <= in_valid;
         if (cl_ready) cl_valid_ff <= sh_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && sh_ready) begin
         sh_ctl_ff  <= in_ctl;
         sh_att_ff  <= in_att;
         sh_def_ff  <= in_def;
         sh_time_ff <= in_time;
         sh_val_ff  <= sh_val_in;
         sh_cap_ff  <= sh_cap_in;
      end
      if (sh_valid_ff && cl_ready) begin
         cl_ctl_ff   <= sh_ctl_ff;
         cl_att_ff   <= sh_att_ff;
         cl_def_ff   <= sh_def_ff;
         cl_time_ff  <= sh_time_ff;
         cl_delay_ff <= cl_delay_in;
      end
   end

   assign out_valid = cl_valid_ff;
   assign out_ctl   = cl_ctl_ff;
   assign out_att   = cl_att_ff;
   assign out_def   = cl_def_ff;
   assign out_time  = cl_time_ff;
   assign out_delay = cl_delay_ff;
endmodule

// File: rtl/rbp_output.sv
module rbp_output
   import rbp_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
   parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ctl_type                in_ctl,
   input  logic [COUNT_WIDTH-1:0] in_att,
   input  logic [COUNT_WIDTH-1:0] in_def,
   input  logic [TIME_WIDTH-1:0]  in_time,
   input  logic [CEIL_W-1:0]      in_delay,
   rbp_rsp_if.source              rsp_chan
);
   logic                   valid_ff;
   logic [1:0]             status_ff;
   logic [COUNT_WIDTH-1:0] att_ff, def_ff;
   logic [TIME_WIDTH:0]    next_ff, next_in;

   assign in_ready = !valid_ff || rsp_chan.ready;
   assign next_in  = (TIME_WIDTH + 1)'(in_time) + (TIME_WIDTH + 1)'(in_delay);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         status_ff <= in_ctl.status;
         att_ff    <= in_att;
         def_ff    <= in_def;
         next_ff   <= next_in;
      end
   end

   assign rsp_chan.valid              = valid_ff;
   assign rsp_chan.new_status         = status_ff;
   assign rsp_chan.new_attempt_count  = att_ff;
   assign rsp_chan.new_deferral_count = def_ff;
   assign rsp_chan.next_attempt_time  = next_ff;
endmodule

// File: rtl/retry_backoff_policy.sv
// Capped exponential backoff for task retries and deferrals.
//
// req_chan carries one task outcome per beat (outcome code, attempt and
// deferral counts, current time, per-type unbounded flags). rsp_chan returns
// one decision beat per request, in order: new status, updated counts and
// next attempt time. csr_* writes the five policy registers; write only
// while no request is in flight.
//
// Pipeline: decode/limit test, ladder shift, ceiling clamp, time add. Each
// stage is a register: the decode register loads at the edge that accepts
// a request, then the shift, clamp and output registers load in turn, and
// the output register drives rsp_chan. While rsp_chan.ready is high, one
// beat can be taken every cycle. The time add is the widest single-cycle path.
//
// Reset (synchronous, active high) empties the pipeline and loads the
// register defaults. When the receiver stalls, the output beat holds and the
// stages behind it keep filling; req_chan.ready drops only once every stage
// is occupied, so nothing is dropped or repeated. With rsp_chan.ready high,
// req_chan.ready is high too.
module retry_backoff_policy
   import rbp_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
   parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   rbp_req_if.sink               req_chan,
   rbp_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   cfg_type cfg;

   // decode -> ladder
   logic                   d_valid, d_ready, d_far;
   ctl_type                d_ctl;
   logic [COUNT_WIDTH-1:0] d_att, d_def;
   logic [TIME_WIDTH-1:0]  d_time;
   logic [BASE_W-1:0]      d_base;
   logic [STEP_W-1:0]      d_steps;

   // ladder -> output
   logic                   l_valid, l_ready;
   ctl_type                l_ctl;
   logic [COUNT_WIDTH-1:0] l_att, l_def;
   logic [TIME_WIDTH-1:0]  l_time;
   logic [CEIL_W-1:0]      l_delay;

   rbp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // counts, status and shift distance
   rbp_decode #(.COUNT_WIDTH(COUNT_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_decode (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_chan  (req_chan),
      .out_ready (d_ready),
      .out_valid (d_valid),
      .out_ctl   (d_ctl),
      .out_att   (d_att),
      .out_def   (d_def),
      .out_time  (d_time),
      .out_base  (d_base),
      .out_steps (d_steps),
      .out_far   (d_far)
   );

   // min(base << (n-1), ceiling), ceiling for a zero base, zero when no wait
   rbp_ladder #(.COUNT_WIDTH(COUNT_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_ladder (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .in_ctl    (d_ctl),
      .in_att    (d_att),
      .in_def    (d_def),
      .in_time   (d_time),
      .in_base   (d_base),
      .in_steps  (d_steps),
      .in_far    (d_far),
      .out_ready (l_ready),
      .out_valid (l_valid),
      .out_ctl   (l_ctl),
      .out_att   (l_att),
      .out_def   (l_def),
      .out_time  (l_time),
      .out_delay (l_delay)
   );

   // time add and output register
   rbp_output #(.COUNT_WIDTH(COUNT_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_output (
      .clock    (clock),
      .reset    (reset),
      .in_valid (l_valid),
      .in_ready (l_ready),
      .in_ctl   (l_ctl),
      .in_att   (l_att),
      .in_def   (l_def),
      .in_time  (l_time),
      .in_delay (l_delay),
      .rsp_chan (rsp_chan)
   );
endmodule

// File: rtl/rbp_checker.sv
module rbp_checker
   import rbp_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
   parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [1:0]             rsp_status,
   input logic [COUNT_WIDTH-1:0] rsp_att,
   input logic [COUNT_WIDTH-1:0] rsp_def,
   input logic [TIME_WIDTH:0]    rsp_next
);
   // pipeline empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a draining output never backs up the request side
   a_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response side drains");

   // a dead letter always follows a counted attempt or deferral
   a_dead_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DEAD |-> (rsp_att != '0 || rsp_def != '0))
      else $error("dead letter with zero counts");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_att) && $stable(rsp_def) && $stable(rsp_next))
      else $error("stalled response beat changed");
endmodule

bind retry_backoff_policy rbp_checker #(
   .COUNT_WIDTH (COUNT_WIDTH),
   .TIME_WIDTH  (TIME_WIDTH)
) u_rbp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.new_status),
   .rsp_att    (rsp_chan.new_attempt_count),
   .rsp_def    (rsp_chan.new_deferral_count),
   .rsp_next   (rsp_chan.next_attempt_time)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rbp_pkg::*;

   localparam int CW = COUNT_WIDTH_DEF;
   localparam int TW = TIME_WIDTH_DEF;

   localparam logic [2:0] OC_UNUSED = 3'd7;  // decodes as a no-op

   localparam int PIPE_LATENCY    = 3;       // accept edge to response valid, in cycles
   localparam int HOLD_OFF_CYCLES = 300;     // receiver blackout for the backpressure test
   localparam int IDLE_LIMIT      = 3000;    // cycles with no beat on either side
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_BEATS     = 240;
   localparam int PRESSURE_BEATS  = 64;

   typedef struct packed {
      logic [2:0]    outcome;
      logic [CW-1:0] attempts;
      logic [CW-1:0] deferrals;
      logic [TW-1:0] now;
      logic          att_unb;
      logic          def_unb;
   } task_outcome_type;

   typedef struct packed {
      logic [1:0]    status;
      logic [CW-1:0] attempts;
      logic [CW-1:0] deferrals;
      logic [TW:0]   next_time;
   } decision_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rbp_req_if req_chan ();
   rbp_rsp_if rsp_chan ();

   retry_backoff_policy dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Mirror of the policy registers, updated on every CSR write.
   cfg_type policy;

   // Decisions predicted at request accept, retired in order by the checker.
   decision_type pending_decisions[$];

   int  mismatch_count = 0;
   int  beats_sent     = 0;
   int  policy_phases  = 0;
   int  status_seen[4] = '{default: 0};
   bit  req_gaps_on    = 1'b1;
   bit  rsp_stalls_on  = 1'b1;
   int  hold_off_reqs  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Policy predictor
   // ------------------------------------------------------------------

   function automatic logic [CW-1:0] bump_count(input logic [CW-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   // min(base << (n-1), ceiling); a zero base means the ceiling outright.
   // Shifting stops as soon as the ceiling is reached, so the loop is short.
   function automatic longint unsigned backoff_delay(input logic [CW-1:0] n,
                                                     input logic [BASE_W-1:0] base);
      longint unsigned delay;
      longint unsigned steps;
      longint unsigned cap;
      longint unsigned i;
      cap = policy.ceiling;
      if (base == '0)
         return cap;
      delay = base;
      steps = (n == '0) ? 0 : n - 1;
      for (i = 0; i < steps && delay < cap; i++)
         delay = delay << 1;
      return (delay > cap) ? cap : delay;
   endfunction

   function automatic decision_type predict_decision(input task_outcome_type t);
      decision_type d;
      d.status    = ST_SCHEDULED;
      d.attempts  = t.attempts;
      d.deferrals = t.deferrals;
      d.next_time = (TW+1)'(t.now);
      case (t.outcome) inside
         OC_OK: d.status = ST_COMPLETED;
         OC_TERMINAL: d.status = ST_FAILED;
         OC_RETRYABLE, OC_TIMEOUT: begin
            d.attempts  = bump_count(t.attempts);
            d.deferrals = '0;
            // limit test uses the saturated count
            if (!t.att_unb && d.attempts >= policy.att_limit)
               d.status = ST_DEAD;
            else
               d.next_time = (TW+1)'(t.now) +
                             (TW+1)'(backoff_delay(d.attempts, policy.retry_base));
         end
         OC_NOT_READY, OC_BUSY: begin
            d.deferrals = bump_count(t.deferrals);
            if (!t.def_unb && d.deferrals >= policy.def_limit)
               d.status = ST_DEAD;
            else
               d.next_time = (TW+1)'(t.now) +
                             (TW+1)'(backoff_delay(d.deferrals, policy.dfr_base));
         end
         OC_INCOMPLETE: d.deferrals = '0;
         default: ;  // unused code: pass-through, no wait
      endcase
      return d;
   endfunction

   // ------------------------------------------------------------------
   // Random helpers
   // ------------------------------------------------------------------

   // Idle length: mostly short, now and then long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 2);
      else if (r < 95)
         return $urandom_range(3, 10);
      return $urandom_range(20, 60);
   endfunction

   // Counts cluster around the active limit so dead letters are frequent,
   // with the rest spread over the full range and the saturation point.
   function automatic logic [CW-1:0] random_count(input int limit);
      int r;
      int v;
      r = $urandom_range(0, 9);
      if (r < 4) begin
         v = limit - 2 + int'($urandom_range(0, 3));
         if (v < 0)
            v = 0;
         return CW'(v);
      end else if (r < 6) begin
         return CW'($urandom_range(0, 20));
      end else if (r < 8) begin
         return CW'($urandom);
      end else if (r == 8) begin
         return '1 - CW'($urandom_range(0, 2));
      end
      return '0;
   endfunction

   function automatic task_outcome_type random_task_outcome();
      task_outcome_type t;
      t.outcome   = ($urandom_range(0, 19) == 0) ? OC_UNUSED : 3'($urandom_range(0, 6));
      t.attempts  = random_count(policy.att_limit);
      t.deferrals = random_count(policy.def_limit);
      case ($urandom_range(0, 9))
         0: t.now = '0;
         1: t.now = '1;
         default: t.now = TW'({$urandom, $urandom});
      endcase
      t.att_unb = ($urandom_range(0, 3) == 0);
      t.def_unb = ($urandom_range(0, 3) == 0);
      return t;
   endfunction

   // Register value: mostly legal range, sometimes zero or all ones on the
   // full write bus (the block keeps only the register's width).
   function automatic logic [CSR_DATA_W-1:0] random_reg_value(input int lo, input int hi);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      else if (r == 1)
         return '1;
      else if (r < 5)
         return CSR_DATA_W'($urandom_range(lo, lo + 10));
      return CSR_DATA_W'($urandom_range(lo, hi));
   endfunction

   function automatic task_outcome_type beat_of(input logic [2:0] oc,
                                                input logic [CW-1:0] att,
                                                input logic [CW-1:0] dfr,
                                                input logic [TW-1:0] now,
                                                input logic au,
                                                input logic du);
      task_outcome_type t;
      t.outcome   = oc;
      t.attempts  = att;
      t.deferrals = dfr;
      t.now       = now;
      t.att_unb   = au;
      t.def_unb   = du;
      return t;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one beat, holding valid across back-to-back beats, and log the
   // predicted decision at the accepting edge.
   task automatic send_beat(input task_outcome_type t);
      int gap;
      gap = req_gaps_on && ($urandom_range(0, 9) < 4) ? idle_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid               <= 1'b1;
      req_chan.outcome             <= t.outcome;
      req_chan.attempt_count       <= t.attempts;
      req_chan.deferral_count      <= t.deferrals;
      req_chan.time_now            <= t.now;
      req_chan.attempts_unbounded  <= t.att_unb;
      req_chan.deferrals_unbounded <= t.def_unb;
      do
         @(posedge clock);
      while (!req_chan.ready);
      pending_decisions.push_back(predict_decision(t));
      beats_sent++;
   endtask

   // Drop valid and let every outstanding decision come back.
   task automatic drain_pipeline();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_decisions.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_policy_reg(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_RETRY_BASE: policy.retry_base = value[BASE_W-1:0];
         REG_CEILING:    policy.ceiling    = value[CEIL_W-1:0];
         REG_DEFER_BASE: policy.dfr_base   = value[BASE_W-1:0];
         REG_ATT_LIMIT:  policy.att_limit  = value[ALIM_W-1:0];
         REG_DEF_LIMIT:  policy.def_limit  = value[DLIM_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Only called with the pipeline empty.
   task automatic apply_policy(input logic [CSR_DATA_W-1:0] retry_base,
                               input logic [CSR_DATA_W-1:0] ceiling,
                               input logic [CSR_DATA_W-1:0] dfr_base,
                               input logic [CSR_DATA_W-1:0] att_limit,
                               input logic [CSR_DATA_W-1:0] def_limit);
      write_policy_reg(REG_RETRY_BASE, retry_base);
      write_policy_reg(REG_CEILING, ceiling);
      write_policy_reg(REG_DEFER_BASE, dfr_base);
      write_policy_reg(REG_ATT_LIMIT, att_limit);
      write_policy_reg(REG_DEF_LIMIT, def_limit);
      policy_phases++;
   endtask

   // ------------------------------------------------------------------
   // Response side: random ready, plus an on-demand long hold-off
   // ------------------------------------------------------------------

   initial begin : rsp_sink
      int run;
      int hold_offs_done;
      run = 0;
      hold_offs_done = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_reqs != hold_offs_done) begin
            hold_offs_done++;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            rsp_chan.ready <= 1'b1;
            run = $urandom_range(5, 20);
         end else if (run > 0) begin
            run--;
         end else if (!rsp_stalls_on || $urandom_range(0, 2) != 0) begin
            rsp_chan.ready <= 1'b1;
            run = $urandom_range(0, 15);
         end else begin
            rsp_chan.ready <= 1'b0;
            run = idle_length() - 1;
         end
      end
   end

   // Retire the oldest prediction on every response beat.
   always @(posedge clock) begin : decision_check
      decision_type want;
      decision_type got;
      bit           bad;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.status    = rsp_chan.new_status;
         got.attempts  = rsp_chan.new_attempt_count;
         got.deferrals = rsp_chan.new_deferral_count;
         got.next_time = rsp_chan.next_attempt_time;
         if (got.status !== 2'bxx)
            status_seen[got.status]++;
         if (pending_decisions.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: response beat with nothing outstanding: status %0d att %0d "
                        , $realtime, got.status, got.attempts,
                        "def %0d next %0d", got.deferrals, got.next_time);
         end else begin
            want = pending_decisions.pop_front();
            bad = (got.status !== want.status) || (got.attempts !== want.attempts) ||
                  (got.deferrals !== want.deferrals) || (got.next_time !== want.next_time);
            if (bad) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: decision mismatch", $realtime);
                  $display("   expected status %0d att %0d def %0d next %0d",
                           want.status, want.attempts, want.deferrals, want.next_time);
                  $display("   actual   status %0d att %0d def %0d next %0d",
                           got.status, got.attempts, got.deferrals, got.next_time);
               end
            end
         end
      end
   end

   // Watchdog: any beat on either channel resets the count.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d decisions outstanding",
                     $realtime, IDLE_LIMIT, pending_decisions.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset values 30/900/5/8/48, no register writes yet.
   task automatic test_default_policy();
      send_beat(beat_of(OC_OK, 16'd3, 16'd7, '0, 1'b0, 1'b0));
      send_beat(beat_of(OC_TERMINAL, '1, '1, '1, 1'b0, 1'b0));
      send_beat(beat_of(OC_RETRYABLE, 16'd0, 16'd9, TW'(1000), 1'b0, 1'b0));  // first retry
      send_beat(beat_of(OC_TIMEOUT, 16'd5, 16'd2, TW'(77), 1'b0, 1'b0));     // hits ceiling
      send_beat(beat_of(OC_RETRYABLE, 16'd7, 16'd0, TW'(5), 1'b0, 1'b0));    // reaches limit
      send_beat(beat_of(OC_RETRYABLE, 16'd7, 16'd0, TW'(5), 1'b1, 1'b0));    // unbounded type
      send_beat(beat_of(OC_RETRYABLE, '1, '1, '1, 1'b1, 1'b1));              // saturates
      send_beat(beat_of(OC_NOT_READY, 16'd4, 16'd0, TW'(12), 1'b0, 1'b0));
      send_beat(beat_of(OC_BUSY, 16'd4, 16'd47, TW'(12), 1'b0, 1'b0));       // defer limit
      send_beat(beat_of(OC_BUSY, '0, '1, '1, 1'b0, 1'b1));                   // saturates
      send_beat(beat_of(OC_INCOMPLETE, 16'd11, 16'd13, TW'(99), 1'b0, 1'b0));
      send_beat(beat_of(OC_UNUSED, 16'hA5A5, 16'h5A5A, TW'(40'hAB_CDEF_0123), 1'b1, 1'b1));
      send_beat(beat_of(OC_OK, '1, '0, '1, 1'b1, 1'b1));
      drain_pipeline();
   endtask

   task automatic test_register_corners();
      // zero bases fall straight to the ceiling; largest ceiling
      apply_policy(17'd0, 17'h1FFFF, 17'd0, 17'd1000, 17'd10000);
      send_beat(beat_of(OC_RETRYABLE, 16'd3, 16'd0, '1, 1'b0, 1'b0));
      send_beat(beat_of(OC_NOT_READY, 16'd0, 16'd9999, TW'(3), 1'b0, 1'b0));
      drain_pipeline();
      // zero ceiling and zero limits
      apply_policy(17'd30, 17'd0, 17'd5, 17'd0, 17'd0);
      send_beat(beat_of(OC_RETRYABLE, 16'd0, 16'd4, TW'(8), 1'b0, 1'b0));
      send_beat(beat_of(OC_BUSY, 16'd0, 16'd0, TW'(8), 1'b0, 1'b1));
      send_beat(beat_of(OC_TIMEOUT, 16'd2, 16'd0, TW'(8), 1'b1, 1'b0));
      drain_pipeline();
      // base above ceiling
      apply_policy(17'd3600, 17'd100, 17'd4095, 17'd8, 17'd48);
      send_beat(beat_of(OC_RETRYABLE, 16'd0, 16'd0, TW'(50), 1'b0, 1'b0));
      send_beat(beat_of(OC_NOT_READY, 16'd0, 16'd0, TW'(50), 1'b0, 1'b0));
      drain_pipeline();
      // all-ones on the write bus: each register keeps its own width
      apply_policy('1, '1, '1, '1, '1);
      send_beat(beat_of(OC_RETRYABLE, 16'd1021, 16'd6, TW'(1), 1'b0, 1'b0));
      send_beat(beat_of(OC_TIMEOUT, 16'd1022, 16'd6, TW'(1), 1'b0, 1'b0));
      send_beat(beat_of(OC_BUSY, 16'd0, 16'd16382, TW'(1), 1'b0, 1'b0));
      send_beat(beat_of(OC_NOT_READY, 16'd0, 16'd2, TW'(1), 1'b0, 1'b0));
      drain_pipeline();
   endtask

   // Random decisions under a series of policies; the first restores the
   // reset values, and one phase runs with no idling on either side.
   task automatic test_random_traffic();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0)
            apply_policy(17'd30, 17'd900, 17'd5, 17'd8, 17'd48);
         else
            apply_policy(random_reg_value(1, 3600), random_reg_value(1, 86400),
                         random_reg_value(1, 3600), random_reg_value(1, 1000),
                         random_reg_value(1, 10000));
         req_gaps_on   = (phase != 3);
         rsp_stalls_on = (phase != 3);
         for (int n = 0; n < PHASE_BEATS; n++)
            send_beat(random_task_outcome());
         drain_pipeline();
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // Receiver goes dark while the sender keeps pushing: the pipeline fills
   // and req ready must drop without losing or repeating a beat.
   task automatic test_backpressure();
      apply_policy(random_reg_value(1, 3600), random_reg_value(1, 86400),
                   random_reg_value(1, 3600), random_reg_value(1, 1000),
                   random_reg_value(1, 10000));
      req_gaps_on = 1'b0;
      hold_off_reqs++;
      for (int n = 0; n < PRESSURE_BEATS; n++)
         send_beat(random_task_outcome());
      drain_pipeline();
      req_gaps_on = 1'b1;
   endtask

   initial begin : main
      req_chan.valid               = 1'b0;
      req_chan.outcome             = '0;
      req_chan.attempt_count       = '0;
      req_chan.deferral_count      = '0;
      req_chan.time_now            = '0;
      req_chan.attempts_unbounded  = 1'b0;
      req_chan.deferrals_unbounded = 1'b0;

      policy.retry_base = RETRY_BASE_RST;
      policy.ceiling    = CEILING_RST;
      policy.dfr_base   = DEFER_BASE_RST;
      policy.att_limit  = ATT_LIMIT_RST;
      policy.def_limit  = DEF_LIMIT_RST;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_policy();
      test_register_corners();
      test_random_traffic();
      test_backpressure();

      // catch any stray beat after the last expected one
      repeat (PIPE_LATENCY * 5) @(posedge clock);

      $display("Covered %0d request beats under %0d policy settings, incl. a %0d-cycle hold-off.",
               beats_sent, policy_phases + 1, HOLD_OFF_CYCLES);
      $display("Decisions: %0d scheduled, %0d completed, %0d dead letter, %0d failed.",
               status_seen[ST_SCHEDULED], status_seen[ST_COMPLETED],
               status_seen[ST_DEAD], status_seen[ST_FAILED]);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/rbp_pkg.sv
rtl/rbp_req_if.sv
rtl/rbp_rsp_if.sv
rtl/rbp_csr.sv
rtl/rbp_decode.sv
rtl/rbp_ladder.sv
rtl/rbp_output.sv
rtl/retry_backoff_policy.sv
rtl/rbp_checker.sv
dv/tb_top.sv
